// ===== rtl/rgbycc_pkg.sv =====
package rgbycc_pkg;

    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LUMA_MAX     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHROMA_MAX   = 2'd3;

    localparam logic [11:0] RST_IMAGE_WIDTH  = 12'd640;
    localparam logic [11:0] RST_IMAGE_HEIGHT = 12'd480;
    localparam logic [7:0]  RST_LUMA_MAX     = 8'd235;
    localparam logic [7:0]  RST_CHROMA_MAX   = 8'd240;

    localparam logic [11:0] HEIGHT_LIMIT = 12'd2048;
    localparam int          ROW_W        = 11;

    localparam int COEF_Y_R  = 33;
    localparam int COEF_Y_G  = 65;
    localparam int COEF_Y_B  = 13;
    localparam int COEF_CB_R = -19;
    localparam int COEF_CB_G = -37;
    localparam int COEF_CB_B = 56;
    localparam int COEF_CR_R = 56;
    localparam int COEF_CR_G = -47;
    localparam int COEF_CR_B = -9;
    localparam int FRAC_BITS = 7;

    localparam logic signed [9:0] LUMA_OFFSET   = 10'sd16;
    localparam logic signed [9:0] CHROMA_OFFSET = 10'sd128;
    localparam logic signed [9:0] CLAMP_LOW     = 10'sd16;

    localparam int SUM_W = 9;

    typedef struct packed {
        logic col_odd;
        logic row_odd;
        logic frame_end;
    } pix_pos_t;

endpackage

// ===== rtl/rgbycc_ram.sv =====
module rgbycc_ram import rgbycc_pkg::*; #(
    parameter int DATA_W = 18,
    parameter int DEPTH  = 1024,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/rgbycc_csc.sv =====
module rgbycc_csc import rgbycc_pkg::*; (
    input  logic [7:0] red,
    input  logic [7:0] green,
    input  logic [7:0] blue,
    input  logic [7:0] luma_max,
    input  logic [7:0] chroma_max,
    output logic [7:0] luma,
    output logic [7:0] cb,
    output logic [7:0] cr
);

    function automatic logic [7:0] clamp_value(input logic signed [9:0] v,
                                               input logic [7:0] hi);
        logic signed [9:0] t;
        begin
            t = v;
            if (t > $signed({2'b00, hi})) begin
                t = $signed({2'b00, hi});
            end
            if (t < CLAMP_LOW) begin
                t = CLAMP_LOW;
            end
            return t[7:0];
        end
    endfunction

    logic [14:0]        y_acc;
    logic signed [16:0] cb_acc;
    logic signed [16:0] cr_acc;
    logic signed [9:0]  y_val;
    logic signed [9:0]  cb_val;
    logic signed [9:0]  cr_val;

    always_comb begin
        y_acc  = 15'(COEF_Y_R * int'(red) + COEF_Y_G * int'(green) + COEF_Y_B * int'(blue));
        cb_acc = 17'(COEF_CB_R * int'(red) + COEF_CB_G * int'(green)
                     + COEF_CB_B * int'(blue));
        cr_acc = 17'(COEF_CR_R * int'(red) + COEF_CR_G * int'(green)
                     + COEF_CR_B * int'(blue));
        y_val  = $signed({2'b00, y_acc[14:FRAC_BITS]}) + LUMA_OFFSET;
        cb_val = 10'(cb_acc >>> FRAC_BITS) + CHROMA_OFFSET;
        cr_val = 10'(cr_acc >>> FRAC_BITS) + CHROMA_OFFSET;
        luma   = clamp_value(y_val, luma_max);
        cb     = clamp_value(cb_val, chroma_max);
        cr     = clamp_value(cr_val, chroma_max);
    end

endmodule

// ===== rtl/rgbycc_chroma.sv =====
module rgbycc_chroma import rgbycc_pkg::*; #(
    parameter int DEPTH = 1024,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    input  logic              pix_move,
    input  pix_pos_t          pix_pos,
    input  logic [ADDR_W-1:0] pix_slot,
    input  logic [7:0]        pix_cb,
    input  logic [7:0]        pix_cr,
    output logic              chroma_valid,
    output logic [7:0]        cb,
    output logic [7:0]        cr
);

    logic [7:0]         held_cb_reg;
    logic [7:0]         held_cr_reg;
    logic [2*SUM_W-1:0] upper_rd;
    logic [SUM_W-1:0]   pair_cb;
    logic [SUM_W-1:0]   pair_cr;
    logic [SUM_W:0]     block_cb;
    logic [SUM_W:0]     block_cr;
    logic               wr_en;

    assign pair_cb  = {1'b0, held_cb_reg} + {1'b0, pix_cb};
    assign pair_cr  = {1'b0, held_cr_reg} + {1'b0, pix_cr};
    assign block_cb = {1'b0, upper_rd[2*SUM_W-1:SUM_W]} + {1'b0, pair_cb};
    assign block_cr = {1'b0, upper_rd[SUM_W-1:0]} + {1'b0, pair_cr};
    assign wr_en    = pix_move && pix_pos.col_odd && !pix_pos.row_odd;

    assign chroma_valid = pix_pos.col_odd && pix_pos.row_odd;
    assign cb = chroma_valid ? block_cb[SUM_W:2] : 8'd0;
    assign cr = chroma_valid ? block_cr[SUM_W:2] : 8'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_cb_reg <= 8'd0;
            held_cr_reg <= 8'd0;
        end else if (pix_move && !pix_pos.col_odd) begin
            held_cb_reg <= pix_cb;
            held_cr_reg <= pix_cr;
        end
    end

    rgbycc_ram #(
        .DATA_W (2*SUM_W),
        .DEPTH  (DEPTH)
    ) u_upper_sums (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (pix_slot),
        .wr_data ({pair_cb, pair_cr}),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (upper_rd)
    );

endmodule

// ===== rtl/rgb_to_ycbcr_420_stream_top.sv =====
// RGB to YCbCr (BT.601 integer coefficients) converter with 4:2:0 chroma
// subsampling for a raster-order pixel stream. One pixel is accepted every
// clock cycle while the output is not stalled, and each pixel gives exactly
// one result beat, carried in order through an input register, the color
// conversion stage register and the output register. Luma comes with every
// beat; cb and cr carry the averaged 2x2 block on the bottom-right pixel,
// flagged by chroma_valid, and are zero otherwise. Top-row pair sums live
// in a line buffer of MAX_WIDTH/2 entries of 18 bits with one read and one
// write port; it needs no clearing after reset. Sizes are taken as even
// and saturated to the supported range, and configuration must only be
// written while no pixel is in flight.
module rgb_to_ycbcr_420_stream_top import rgbycc_pkg::*; #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_red,
    input  logic [7:0]            s_green,
    input  logic [7:0]            s_blue,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_luma,
    output logic                  m_chroma_valid,
    output logic [7:0]            m_cb,
    output logic [7:0]            m_cr,
    output logic                  m_frame_end
);

    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int SIZE_W     = (COL_W + 1 > 12) ? COL_W + 1 : 12;

    logic [11:0] image_width_reg;
    logic [11:0] image_height_reg;
    logic [7:0]  luma_max_reg;
    logic [7:0]  chroma_max_reg;

    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;

    logic [SIZE_W-1:0] width_even;
    logic [SIZE_W-1:0] width_sat;
    logic [11:0]       height_even;
    logic [11:0]       height_sat;
    logic              last_col;
    logic              last_row;
    logic              s_accept;

    logic              a_valid_reg;
    logic [7:0]        a_red_reg;
    logic [7:0]        a_green_reg;
    logic [7:0]        a_blue_reg;
    pix_pos_t          a_pos_reg;
    logic [ADDR_W-1:0] a_slot_reg;

    logic              b_valid_reg;
    logic [7:0]        b_luma_reg;
    logic [7:0]        b_cb_reg;
    logic [7:0]        b_cr_reg;
    pix_pos_t          b_pos_reg;
    logic [ADDR_W-1:0] b_slot_reg;

    logic              m_valid_reg;
    logic [7:0]        m_luma_reg;
    logic              m_chroma_valid_reg;
    logic [7:0]        m_cb_reg;
    logic [7:0]        m_cr_reg;
    logic              m_frame_end_reg;

    logic       c_free;
    logic       b_move;
    logic       b_free;
    logic       a_move;
    logic [7:0] csc_luma;
    logic [7:0] csc_cb;
    logic [7:0] csc_cr;
    logic       sub_valid;
    logic [7:0] sub_cb;
    logic [7:0] sub_cr;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= RST_IMAGE_WIDTH;
            image_height_reg <= RST_IMAGE_HEIGHT;
            luma_max_reg     <= RST_LUMA_MAX;
            chroma_max_reg   <= RST_CHROMA_MAX;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[11:0];
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[11:0];
                REG_LUMA_MAX:     luma_max_reg     <= cfg_data[7:0];
                REG_CHROMA_MAX:   chroma_max_reg   <= cfg_data[7:0];
                default:          ;
            endcase
        end
    end

    always_comb begin
        width_even = SIZE_W'({image_width_reg[11:1], 1'b0});
        width_sat  = width_even;
        if (width_even < SIZE_W'(2)) begin
            width_sat = SIZE_W'(2);
        end else if (width_even > SIZE_W'(MAX_WIDTH)) begin
            width_sat = SIZE_W'(MAX_WIDTH);
        end
        height_even = {image_height_reg[11:1], 1'b0};
        height_sat  = height_even;
        if (height_even < 12'd2) begin
            height_sat = 12'd2;
        end else if (height_even > HEIGHT_LIMIT) begin
            height_sat = HEIGHT_LIMIT;
        end
        last_col = SIZE_W'(col_reg) >= (width_sat - SIZE_W'(1));
        last_row = {1'b0, row_reg} >= (height_sat - 12'd1);
    end

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (s_accept) begin
            if (last_col) begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + ROW_W'(1);
            end else begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    assign c_free   = !m_valid_reg || m_ready;
    assign b_move   = b_valid_reg && c_free;
    assign b_free   = !b_valid_reg || b_move;
    assign a_move   = a_valid_reg && b_free;
    assign s_ready  = !a_valid_reg || a_move;
    assign s_accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            row_reg     <= '0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (s_ready) begin
                a_valid_reg <= s_valid;
            end
            if (b_free) begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_free) begin
                m_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            a_red_reg           <= s_red;
            a_green_reg         <= s_green;
            a_blue_reg          <= s_blue;
            a_pos_reg.col_odd   <= col_reg[0];
            a_pos_reg.row_odd   <= row_reg[0];
            a_pos_reg.frame_end <= last_col && last_row;
            a_slot_reg          <= ADDR_W'(col_reg >> 1);
        end
        if (a_move) begin
            b_luma_reg <= csc_luma;
            b_cb_reg   <= csc_cb;
            b_cr_reg   <= csc_cr;
            b_pos_reg  <= a_pos_reg;
            b_slot_reg <= a_slot_reg;
        end
        if (b_move) begin
            m_luma_reg         <= b_luma_reg;
            m_chroma_valid_reg <= sub_valid;
            m_cb_reg           <= sub_cb;
            m_cr_reg           <= sub_cr;
            m_frame_end_reg    <= b_pos_reg.frame_end;
        end
    end

    rgbycc_csc u_csc (
        .red        (a_red_reg),
        .green      (a_green_reg),
        .blue       (a_blue_reg),
        .luma_max   (luma_max_reg),
        .chroma_max (chroma_max_reg),
        .luma       (csc_luma),
        .cb         (csc_cb),
        .cr         (csc_cr)
    );

    rgbycc_chroma #(
        .DEPTH (LINE_DEPTH)
    ) u_chroma (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .rd_en        (a_move),
        .rd_addr      (a_slot_reg),
        .pix_move     (b_move),
        .pix_pos      (b_pos_reg),
        .pix_slot     (b_slot_reg),
        .pix_cb       (b_cb_reg),
        .pix_cr       (b_cr_reg),
        .chroma_valid (sub_valid),
        .cb           (sub_cb),
        .cr           (sub_cr)
    );

    assign m_valid        = m_valid_reg;
    assign m_luma         = m_luma_reg;
    assign m_chroma_valid = m_chroma_valid_reg;
    assign m_cb           = m_cb_reg;
    assign m_cr           = m_cr_reg;
    assign m_frame_end    = m_frame_end_reg;

    a_chroma_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_chroma_valid |-> m_cb == 8'd0 && m_cr == 8'd0)
        else $error("chroma fields not zero on a beat without a block result");

    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        a_valid_reg && !a_move |=> a_valid_reg && $stable(a_red_reg)
            && $stable(a_slot_reg))
        else $error("stalled input stage lost or changed its pixel");

    a_col_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        SIZE_W'(col_reg) < SIZE_W'(MAX_WIDTH))
        else $error("column counter beyond the line buffer");

    a_output_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_luma) && $stable(m_cb))
        else $error("stalled result beat changed");

endmodule
